/* rtl/tsp_pkg.sv */
// Shared types, constants and the register address table for the temperature
// sensor poller. No dependencies.
package tsp_pkg;

	localparam int READ_COUNT = 6;
	localparam int SLOT_W = 3;

	localparam logic [2:0] PH_CFG_WRITE = 3'd0;
	localparam logic [2:0] PH_CFG_WAIT = 3'd1;
	localparam logic [2:0] PH_DELAY = 3'd2;
	localparam logic [2:0] PH_RD_SETUP = 3'd3;
	localparam logic [2:0] PH_RD_OFFER = 3'd4;
	localparam logic [2:0] PH_RD_WAIT = 3'd5;

	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	localparam logic [1:0] CFG_PERIOD_US = 2'd0;
	localparam logic [1:0] CFG_SETUP_BYTE = 2'd1;
	localparam logic [1:0] CFG_EXPECTED_ID = 2'd2;

	localparam logic [31:0] PERIOD_US_RST = 32'd1000000;
	localparam logic [7:0] SETUP_BYTE_RST = 8'h04;
	localparam logic [7:0] EXPECTED_ID_RST = 8'h20;

	localparam logic [7:0] REG_CONFIG = 8'h03;
	localparam logic [7:0] REG_ID = 8'hFD;
	localparam logic [7:0] REG_STATUS = 8'h02;
	localparam logic [7:0] REG_INT_HIGH = 8'h00;
	localparam logic [7:0] REG_INT_LOW = 8'h29;
	localparam logic [7:0] REG_EXT_HIGH = 8'h01;
	localparam logic [7:0] REG_EXT_LOW = 8'h10;

	localparam logic [SLOT_W-1:0] SLOT_ID = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_INT_HIGH = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_INT_LOW = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_EXT_HIGH = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_EXT_LOW = 3'd5;

	typedef struct packed {
		logic [31:0] period_us;
		logic [7:0] setup_byte;
		logic [7:0] expected_id;
	} tsp_cfg_t;

	typedef struct packed {
		logic request_valid;
		logic request_is_read;
		logic [7:0] request_register;
		logic [7:0] request_data;
		logic signed [15:0] internal_temp;
		logic signed [15:0] external_temp;
	} tsp_result_t;

	function automatic logic [7:0] read_reg_addr(input logic [SLOT_W-1:0] slot);
		logic [7:0] addr;
		case (slot)
			3'd0: addr = REG_ID;
			3'd1: addr = REG_STATUS;
			3'd2: addr = REG_INT_HIGH;
			3'd3: addr = REG_INT_LOW;
			3'd4: addr = REG_EXT_HIGH;
			3'd5: addr = REG_EXT_LOW;
			default: addr = REG_ID;
		endcase
		return addr;
	endfunction

endpackage

/* rtl/tsp_conv.sv */
// Converts a sensor high/low byte pair into hundredths of a degree Celsius.
// Uses no package; purely combinational.
module tsp_conv (
	input logic [7:0] hi,
	input logic [7:0] lo,
	output logic signed [15:0] temp
);

	logic [10:0] code;
	logic [15:0] scaled;
	logic signed [16:0] fifth;
	logic signed [16:0] half;

	// The milli-degree value is code*125 - 64000; one fifth of it is exact,
	// and halving that with rounding toward zero gives the tenth.
	always_comb begin
		code = {hi, lo[7:5]};
		scaled = {1'b0, code, 4'b0} + {2'b0, code, 3'b0} + {5'b0, code};
		fifth = $signed({1'b0, scaled}) - 17'sd12800;
		if (fifth < 0) begin
			half = (fifth + 17'sd1) >>> 1;
		end else begin
			half = fifth >>> 1;
		end
		temp = half[15:0];
	end

endmodule

/* rtl/tsp_ctrl.sv */
// Poll sequencer: phase state, read slot, stored bytes, cycle time and
// temperatures. Depends on tsp_pkg and tsp_conv.
module tsp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input tsp_pkg::tsp_cfg_t cfg,
	input logic kickoff_accepted,
	input logic [1:0] xfer_status,
	input logic [7:0] read_byte,
	input logic [31:0] now_us,
	output tsp_pkg::tsp_result_t result
);

	logic [2:0] phase_q;
	logic [2:0] phase_d;
	logic [tsp_pkg::SLOT_W-1:0] slot_q;
	logic [tsp_pkg::SLOT_W-1:0] slot_d;
	logic [tsp_pkg::SLOT_W-1:0] slot_eff;
	logic [tsp_pkg::SLOT_W-1:0] slot_inc;
	logic [7:0] bytes_q [tsp_pkg::READ_COUNT];
	logic [7:0] bytes_d [tsp_pkg::READ_COUNT];
	logic [31:0] last_q;
	logic [31:0] last_d;
	logic [31:0] elapsed;
	logic signed [15:0] int_temp_q;
	logic signed [15:0] ext_temp_q;
	logic signed [15:0] int_temp_d;
	logic signed [15:0] ext_temp_d;
	logic signed [15:0] int_conv;
	logic signed [15:0] ext_conv;
	logic store_byte;
	logic update_temps;

	tsp_conv u_conv_int (
		.hi(bytes_d[tsp_pkg::SLOT_INT_HIGH]),
		.lo(bytes_d[tsp_pkg::SLOT_INT_LOW]),
		.temp(int_conv)
	);

	tsp_conv u_conv_ext (
		.hi(bytes_d[tsp_pkg::SLOT_EXT_HIGH]),
		.lo(bytes_d[tsp_pkg::SLOT_EXT_LOW]),
		.temp(ext_conv)
	);

	always_comb begin
		slot_eff = (slot_q >= tsp_pkg::SLOT_W'(tsp_pkg::READ_COUNT)) ? '0 : slot_q;
		slot_inc = slot_eff + 1'b1;
		elapsed = now_us - last_q;
		phase_d = phase_q;
		slot_d = slot_eff;
		last_d = last_q;
		store_byte = 1'b0;
		update_temps = 1'b0;
		result.request_valid = 1'b0;
		result.request_is_read = 1'b0;
		result.request_register = '0;
		result.request_data = '0;
		case (phase_q)
			tsp_pkg::PH_CFG_WRITE: begin
				result.request_valid = 1'b1;
				result.request_register = tsp_pkg::REG_CONFIG;
				result.request_data = cfg.setup_byte;
				if (kickoff_accepted) phase_d = tsp_pkg::PH_CFG_WAIT;
			end
			tsp_pkg::PH_CFG_WAIT: begin
				if (xfer_status == tsp_pkg::ST_DONE) begin
					phase_d = tsp_pkg::PH_DELAY;
				end else if (xfer_status == tsp_pkg::ST_ERROR) begin
					phase_d = tsp_pkg::PH_CFG_WRITE;
				end
			end
			tsp_pkg::PH_DELAY: begin
				if (elapsed > cfg.period_us) begin
					phase_d = tsp_pkg::PH_RD_SETUP;
					last_d = now_us;
				end
			end
			tsp_pkg::PH_RD_SETUP: begin
				phase_d = tsp_pkg::PH_RD_OFFER;
			end
			tsp_pkg::PH_RD_OFFER: begin
				result.request_valid = 1'b1;
				result.request_is_read = 1'b1;
				result.request_register = tsp_pkg::read_reg_addr(slot_eff);
				if (kickoff_accepted) phase_d = tsp_pkg::PH_RD_WAIT;
			end
			tsp_pkg::PH_RD_WAIT: begin
				if (xfer_status == tsp_pkg::ST_DONE) begin
					store_byte = 1'b1;
					if (slot_inc >= tsp_pkg::SLOT_W'(tsp_pkg::READ_COUNT)) begin
						update_temps = 1'b1;
						slot_d = '0;
						phase_d = tsp_pkg::PH_DELAY;
					end else begin
						slot_d = slot_inc;
						phase_d = tsp_pkg::PH_RD_SETUP;
					end
				end else if (xfer_status == tsp_pkg::ST_ERROR) begin
					slot_d = '0;
					phase_d = tsp_pkg::PH_RD_SETUP;
				end
			end
			default: begin
				phase_d = tsp_pkg::PH_CFG_WRITE;
			end
		endcase

		for (int i = 0; i < tsp_pkg::READ_COUNT; i++) begin
			bytes_d[i] = (store_byte && slot_eff == tsp_pkg::SLOT_W'(i)) ? read_byte : bytes_q[i];
		end

		int_temp_d = int_temp_q;
		ext_temp_d = ext_temp_q;
		if (update_temps && bytes_d[tsp_pkg::SLOT_ID] == cfg.expected_id) begin
			int_temp_d = int_conv;
			ext_temp_d = ext_conv;
		end
		result.internal_temp = int_temp_d;
		result.external_temp = ext_temp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsp_pkg::PH_CFG_WRITE;
			slot_q <= '0;
			last_q <= '0;
			int_temp_q <= '0;
			ext_temp_q <= '0;
			for (int i = 0; i < tsp_pkg::READ_COUNT; i++) begin
				bytes_q[i] <= '0;
			end
		end else if (fire) begin
			phase_q <= phase_d;
			slot_q <= slot_d;
			last_q <= last_d;
			int_temp_q <= int_temp_d;
			ext_temp_q <= ext_temp_d;
			for (int i = 0; i < tsp_pkg::READ_COUNT; i++) begin
				bytes_q[i] <= bytes_d[i];
			end
		end
	end

endmodule

/* rtl/i2c_temp_sensor_poller_core.sv */
// Top level of the temperature sensor poller: configuration registers, input
// word register and result register around the sequencer. Depends on tsp_pkg
// and tsp_ctrl.

// One poll word enters per clock while the held result is not stalled, and
// each yields one result word; a word waits in the input register and then
// moves into the result register, where its result is presented, so the block
// sustains one word per clock under that same condition. The
// sequencer state, held in tsp_ctrl, is updated once per word as it moves from
// the input register to the result register. The input side stalls only while
// a word waits in the input register and the held result is itself stalled.
// Temperatures come out in hundredths of a degree Celsius and show the value
// after the update made by the same word.
module i2c_temp_sensor_poller_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic kickoff_accepted,
	input logic [1:0] xfer_status,
	input logic [7:0] read_byte,
	input logic [31:0] now_us,
	output logic out_valid,
	input logic out_stall,
	output logic request_valid,
	output logic request_is_read,
	output logic [7:0] request_register,
	output logic [7:0] request_data,
	output logic signed [15:0] internal_temp,
	output logic signed [15:0] external_temp
);

	tsp_pkg::tsp_cfg_t cfg_q;
	logic valid_s1;
	logic kick_s1;
	logic [1:0] status_s1;
	logic [7:0] rbyte_s1;
	logic [31:0] now_s1;
	logic out_valid_q;
	tsp_pkg::tsp_result_t res_q;
	tsp_pkg::tsp_result_t res_d;
	logic fire;
	logic in_accept;

	assign fire = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_us <= tsp_pkg::PERIOD_US_RST;
			cfg_q.setup_byte <= tsp_pkg::SETUP_BYTE_RST;
			cfg_q.expected_id <= tsp_pkg::EXPECTED_ID_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tsp_pkg::CFG_PERIOD_US: cfg_q.period_us <= cfg_data;
				tsp_pkg::CFG_SETUP_BYTE: cfg_q.setup_byte <= cfg_data[7:0];
				tsp_pkg::CFG_EXPECTED_ID: cfg_q.expected_id <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kick_s1 <= kickoff_accepted;
			status_s1 <= xfer_status;
			rbyte_s1 <= read_byte;
			now_s1 <= now_us;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	tsp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.cfg(cfg_q),
		.kickoff_accepted(kick_s1),
		.xfer_status(status_s1),
		.read_byte(rbyte_s1),
		.now_us(now_s1),
		.result(res_d)
	);

	assign out_valid = out_valid_q;
	assign request_valid = res_q.request_valid;
	assign request_is_read = res_q.request_is_read;
	assign request_register = res_q.request_register;
	assign request_data = res_q.request_data;
	assign internal_temp = res_q.internal_temp;
	assign external_temp = res_q.external_temp;

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("Input stalled while the result register could take a word.");

	a_idle_request_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !request_valid) |->
		(!request_is_read && request_register == 8'h00 && request_data == 8'h00))
		else $error("Request fields not cleared with no transfer offered.");

	a_write_is_config: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && request_valid && !request_is_read) |->
		(request_register == tsp_pkg::REG_CONFIG))
		else $error("Write offered to a register other than the configuration register.");

	a_read_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && request_valid && request_is_read) |-> (request_data == 8'h00))
		else $error("Read request carries nonzero data.");

endmodule
